FILE: src/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Types and constants shared by the video register port blocks.
// ----------------------------------------------------------------------------
package vrp_pkg;

   // operation codes of an input beat
   localparam logic [2:0] OP_READ       = 3'd0;
   localparam logic [2:0] OP_WRITE      = 3'd1;
   localparam logic [2:0] OP_DMA_START  = 3'd2;
   localparam logic [2:0] OP_DMA_BYTE   = 3'd3;
   localparam logic [2:0] OP_VBL_START  = 3'd4;
   localparam logic [2:0] OP_VBL_END    = 3'd5;

   // register indexes
   localparam logic [2:0] REG_CTRL    = 3'd0;
   localparam logic [2:0] REG_MASK    = 3'd1;
   localparam logic [2:0] REG_STATUS  = 3'd2;
   localparam logic [2:0] REG_OAMADDR = 3'd3;
   localparam logic [2:0] REG_OAMDATA = 3'd4;
   localparam logic [2:0] REG_SCROLL  = 3'd5;
   localparam logic [2:0] REG_ADDR    = 3'd6;
   localparam logic [2:0] REG_DATA    = 3'd7;

   // temp address keep masks
   localparam logic [14:0] T_NT_KEEP      = 15'h73FF;
   localparam logic [14:0] T_COARSEX_KEEP = 15'h7FE0;
   localparam logic [14:0] T_FINEY_KEEP   = 15'h0FFF;
   localparam logic [14:0] T_COARSEY_KEEP = 15'h7C1F;

   // video address map
   localparam logic [13:0] PALETTE_BASE   = 14'h3F00;
   localparam logic [13:0] PALETTE_MIRROR = 14'h2FFF;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] reg_index;
      logic [7:0] wdata;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       nmi_request;
   } rsp_type;

   typedef enum logic [2:0] {
      RK_NONE,
      RK_LATCH,
      RK_STATUS,
      RK_SPRITE,
      RK_BUFFERED,
      RK_PALETTE,
      RK_WRITE
   } rsp_kind_type;

   typedef struct packed {
      rsp_kind_type kind;
      logic [7:0]   wdata;
      logic [2:0]   status_hi;
      logic         nmi;
   } stage_type;

   typedef struct packed {
      logic vmem_we;
      logic vmem_re;
      logic smem_we;
      logic smem_re;
   } mem_ctl_type;

endpackage

FILE: src/vrp_ram.sv
// ----------------------------------------------------------------------------
// vrp_ram
// Single port write, single port read RAM with registered read data.
// ----------------------------------------------------------------------------
module vrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/vrp_regs.sv
// ----------------------------------------------------------------------------
// vrp_regs
// Register file and scroll/address latches; issues memory accesses per beat.
// ----------------------------------------------------------------------------
module vrp_regs #(
   parameter int VRAM_ADDR_BITS   = 14,
   parameter int SPRITE_MEM_BYTES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  vrp_pkg::req_type                    req,
   output vrp_pkg::mem_ctl_type                mem_ctl,
   output logic [VRAM_ADDR_BITS-1:0]           vmem_addr_a,
   output logic [VRAM_ADDR_BITS-1:0]           vmem_addr_b,
   output logic [$clog2(SPRITE_MEM_BYTES)-1:0] smem_addr,
   output vrp_pkg::stage_type                  stage
);

   import vrp_pkg::*;

   localparam int SA_W = $clog2(SPRITE_MEM_BYTES);

   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  sprite_ptr_ff, sprite_ptr_in;
   logic [14:0] temp_addr_ff, temp_addr_in;
   logic [15:0] vram_addr_ff, vram_addr_in;
   logic [2:0]  fine_x_ff, fine_x_in;
   logic        toggle_ff, toggle_in;

   logic [13:0] vaddr;
   logic [13:0] vaddr_mirror;
   logic [15:0] vram_step;

   assign vaddr        = vram_addr_ff[13:0];
   assign vaddr_mirror = vaddr & PALETTE_MIRROR;
   assign vram_step    = ctrl_ff[2] ? 16'd32 : 16'd1;
   assign vmem_addr_a  = vaddr[VRAM_ADDR_BITS-1:0];
   assign vmem_addr_b  = vaddr_mirror[VRAM_ADDR_BITS-1:0];
   assign smem_addr    = sprite_ptr_ff[SA_W-1:0];

   always_comb begin
      logic [14:0] t_mid;
      t_mid           = '0;
      ctrl_in         = ctrl_ff;
      mask_in         = mask_ff;
      status_in       = status_ff;
      sprite_ptr_in   = sprite_ptr_ff;
      temp_addr_in    = temp_addr_ff;
      vram_addr_in    = vram_addr_ff;
      fine_x_in       = fine_x_ff;
      toggle_in       = toggle_ff;
      mem_ctl         = '0;
      stage.kind      = RK_NONE;
      stage.wdata     = req.wdata;
      stage.status_hi = status_ff[7:5];
      stage.nmi       = 1'b0;
      if (accept) begin
         case (req.op)
            OP_READ: begin
               case (req.reg_index)
                  REG_STATUS: begin
                     stage.kind   = RK_STATUS;
                     status_in[7] = 1'b0;
                     toggle_in    = 1'b0;
                  end
                  REG_OAMDATA: begin
                     stage.kind      = RK_SPRITE;
                     mem_ctl.smem_re = 1'b1;
                  end
                  REG_DATA: begin
                     stage.kind      = (vaddr >= PALETTE_BASE) ? RK_PALETTE : RK_BUFFERED;
                     mem_ctl.vmem_re = 1'b1;
                     vram_addr_in    = vram_addr_ff + vram_step;
                  end
                  default: begin
                     stage.kind = RK_LATCH;
                  end
               endcase
            end
            OP_WRITE: begin
               stage.kind = RK_WRITE;
               case (req.reg_index)
                  REG_CTRL: begin
                     ctrl_in      = req.wdata;
                     temp_addr_in = (temp_addr_ff & T_NT_KEEP) | {3'b0, req.wdata[1:0], 10'b0};
                  end
                  REG_MASK: begin
                     mask_in = req.wdata;
                  end
                  REG_OAMADDR: begin
                     sprite_ptr_in = req.wdata;
                  end
                  REG_OAMDATA: begin
                     mem_ctl.smem_we = 1'b1;
                     sprite_ptr_in   = sprite_ptr_ff + 8'd1;
                  end
                  REG_SCROLL: begin
                     if (!toggle_ff) begin
                        temp_addr_in = (temp_addr_ff & T_COARSEX_KEEP) | {10'b0, req.wdata[7:3]};
                        fine_x_in    = req.wdata[2:0];
                     end else begin
                        t_mid        = (temp_addr_ff & T_FINEY_KEEP) | {req.wdata[2:0], 12'b0};
                        temp_addr_in = (t_mid & T_COARSEY_KEEP) | {5'b0, req.wdata[7:3], 5'b0};
                     end
                     toggle_in = ~toggle_ff;
                  end
                  REG_ADDR: begin
                     if (!toggle_ff) begin
                        temp_addr_in = {1'b0, req.wdata[5:0], temp_addr_ff[7:0]};
                     end else begin
                        temp_addr_in = {temp_addr_ff[14:8], req.wdata};
                        vram_addr_in = {1'b0, temp_addr_ff[14:8], req.wdata};
                     end
                     toggle_in = ~toggle_ff;
                  end
                  REG_DATA: begin
                     mem_ctl.vmem_we = 1'b1;
                     vram_addr_in    = vram_addr_ff + vram_step;
                  end
                  default: begin
                  end
               endcase
            end
            OP_DMA_START: begin
               sprite_ptr_in = '0;
            end
            OP_DMA_BYTE: begin
               mem_ctl.smem_we = 1'b1;
               sprite_ptr_in   = sprite_ptr_ff + 8'd1;
            end
            OP_VBL_START: begin
               status_in[7] = 1'b1;
               stage.nmi    = ctrl_ff[7];
            end
            OP_VBL_END: begin
               status_in[7] = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff       <= '0;
         mask_ff       <= '0;
         status_ff     <= '0;
         sprite_ptr_ff <= '0;
         temp_addr_ff  <= '0;
         vram_addr_ff  <= '0;
         fine_x_ff     <= '0;
         toggle_ff     <= 1'b0;
      end else begin
         ctrl_ff       <= ctrl_in;
         mask_ff       <= mask_in;
         status_ff     <= status_in;
         sprite_ptr_ff <= sprite_ptr_in;
         temp_addr_ff  <= temp_addr_in;
         vram_addr_ff  <= vram_addr_in;
         fine_x_ff     <= fine_x_in;
         toggle_ff     <= toggle_in;
      end
   end

endmodule

FILE: src/vrp_resp.sv
// ----------------------------------------------------------------------------
// vrp_resp
// Read data stage: merges memory data, updates bus latch and read buffer,
// and holds the result beat.
// ----------------------------------------------------------------------------
module vrp_resp (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  vrp_pkg::stage_type stage_in,
   input  logic [7:0]         vmem_a_q,
   input  logic [7:0]         vmem_b_q,
   input  logic [7:0]         smem_q,
   input  logic               rsp_stall,
   output logic               hold,
   output logic               rsp_valid,
   output vrp_pkg::rsp_type   rsp_data
);

   import vrp_pkg::*;

   logic       stage_valid_ff, stage_valid_in;
   stage_type  stage_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_next;
   logic [7:0] bus_latch_ff, bus_latch_in;
   logic [7:0] read_buffer_ff, read_buffer_in;
   logic       advance;

   assign advance = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign hold    = stage_valid_ff && !advance;

   always_comb begin
      rsp_next.read_data   = '0;
      rsp_next.nmi_request = stage_ff.nmi;
      bus_latch_in         = bus_latch_ff;
      read_buffer_in       = read_buffer_ff;
      case (stage_ff.kind)
         RK_LATCH: begin
            rsp_next.read_data = bus_latch_ff;
         end
         RK_STATUS: begin
            rsp_next.read_data = {stage_ff.status_hi, bus_latch_ff[4:0]};
            bus_latch_in       = {stage_ff.status_hi, bus_latch_ff[4:0]};
         end
         RK_SPRITE: begin
            rsp_next.read_data = smem_q;
            bus_latch_in       = smem_q;
         end
         RK_BUFFERED: begin
            rsp_next.read_data = read_buffer_ff;
            bus_latch_in       = read_buffer_ff;
            read_buffer_in     = vmem_a_q;
         end
         RK_PALETTE: begin
            rsp_next.read_data = vmem_a_q;
            bus_latch_in       = vmem_a_q;
            read_buffer_in     = vmem_b_q;
         end
         RK_WRITE: begin
            bus_latch_in = stage_ff.wdata;
         end
         default: begin
         end
      endcase
      stage_valid_in = load || (stage_valid_ff && !advance);
      rsp_valid_in   = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         bus_latch_ff   <= '0;
         read_buffer_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            bus_latch_ff   <= bus_latch_in;
            read_buffer_ff <= read_buffer_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/video_register_port_with_scroll_latch_top.sv
// Throughput: one beat per cycle while req_stall is low; a data or sprite
//   data read beat reads the video or sprite memory synchronously, and the
//   registered read data is merged into the response beat in vrp_resp.
// Reset: control registers clear at once, then a clearing pass over all
//   2**VRAM_ADDR_BITS video addresses zeroes both memories with req_stall high.
// ----------------------------------------------------------------------------
// video_register_port_with_scroll_latch_top
// CPU register port of a tile video processor with scroll/address latches,
// sprite memory and video memory.
// ----------------------------------------------------------------------------
module video_register_port_with_scroll_latch_top #(
   parameter int VRAM_ADDR_BITS   = 14,
   parameter int SPRITE_MEM_BYTES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vrp_pkg::rsp_type rsp_data
);

   import vrp_pkg::*;

   localparam int SA_W = $clog2(SPRITE_MEM_BYTES);

   logic [VRAM_ADDR_BITS:0]   clr_cnt_ff, clr_cnt_in;
   logic                      clearing;
   logic                      accept;
   logic                      hold;
   mem_ctl_type               mem_ctl;
   stage_type                 stage;
   logic [VRAM_ADDR_BITS-1:0] vmem_addr_a;
   logic [VRAM_ADDR_BITS-1:0] vmem_addr_b;
   logic [SA_W-1:0]           smem_addr;
   logic                      vmem_we;
   logic [VRAM_ADDR_BITS-1:0] vmem_waddr;
   logic [7:0]                vmem_wdata;
   logic                      smem_we;
   logic [SA_W-1:0]           smem_waddr;
   logic [7:0]                vmem_a_q;
   logic [7:0]                vmem_b_q;
   logic [7:0]                smem_q;

   assign clearing  = !clr_cnt_ff[VRAM_ADDR_BITS];
   assign clr_cnt_in = clearing ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign req_stall = clearing || hold;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign vmem_we    = clearing || mem_ctl.vmem_we;
   assign vmem_waddr = clearing ? clr_cnt_ff[VRAM_ADDR_BITS-1:0] : vmem_addr_a;
   assign vmem_wdata = clearing ? 8'd0 : req_data.wdata;
   assign smem_we    = clearing || mem_ctl.smem_we;
   assign smem_waddr = clearing ? clr_cnt_ff[SA_W-1:0] : smem_addr;

   vrp_regs #(
      .VRAM_ADDR_BITS   (VRAM_ADDR_BITS),
      .SPRITE_MEM_BYTES (SPRITE_MEM_BYTES)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .mem_ctl     (mem_ctl),
      .vmem_addr_a (vmem_addr_a),
      .vmem_addr_b (vmem_addr_b),
      .smem_addr   (smem_addr),
      .stage       (stage)
   );

   // two copies of video memory give the direct and mirrored palette reads
   vrp_ram #(
      .WIDTH (8),
      .DEPTH (2 ** VRAM_ADDR_BITS)
   ) u_vmem_a (
      .clock (clock),
      .we    (vmem_we),
      .waddr (vmem_waddr),
      .wdata (vmem_wdata),
      .re    (mem_ctl.vmem_re),
      .raddr (vmem_addr_a),
      .rdata (vmem_a_q)
   );

   vrp_ram #(
      .WIDTH (8),
      .DEPTH (2 ** VRAM_ADDR_BITS)
   ) u_vmem_b (
      .clock (clock),
      .we    (vmem_we),
      .waddr (vmem_waddr),
      .wdata (vmem_wdata),
      .re    (mem_ctl.vmem_re),
      .raddr (vmem_addr_b),
      .rdata (vmem_b_q)
   );

   vrp_ram #(
      .WIDTH (8),
      .DEPTH (SPRITE_MEM_BYTES)
   ) u_smem (
      .clock (clock),
      .we    (smem_we),
      .waddr (smem_waddr),
      .wdata (vmem_wdata),
      .re    (mem_ctl.smem_re),
      .raddr (smem_addr),
      .rdata (smem_q)
   );

   vrp_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .stage_in  (stage),
      .vmem_a_q  (vmem_a_q),
      .vmem_b_q  (vmem_b_q),
      .smem_q    (smem_q),
      .rsp_stall (rsp_stall),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
